// ===== src/bhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bhc_pkg;

	localparam int CFG_W = 20;

	typedef enum logic [1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_HOLD     = 2'd1,
		CFG_WINDOW   = 2'd2
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 20'd50;
	localparam logic [CFG_W-1:0] HOLD_RST     = 20'd10000;
	localparam logic [CFG_W-1:0] WINDOW_RST   = 20'd5000;

	typedef enum logic [1:0] {
		KIND_OBSERVE = 2'd0,
		KIND_CANCEL  = 2'd1,
		KIND_REARM   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_AWAIT  = 3'd1,
		PH_HOLD   = 3'd2,
		PH_PHELD  = 3'd3,
		PH_CREADY = 3'd4,
		PH_CPRESS = 3'd5,
		PH_COMMIT = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_PROMPT    = 2'd1,
		EV_CANCELLED = 2'd2,
		EV_COMMIT    = 2'd3
	} event_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] hold_ms;
		logic [CFG_W-1:0] confirm_window_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] time_now;
		logic        button_level;
		logic [1:0]  kind;
	} item_t;

	// packed low to high: event_code, rearm_accepted, prompt_shown, phase_now
	typedef struct packed {
		phase_t phase_now;
		logic   prompt_shown;
		logic   rearm_accepted;
		event_t event_code;
	} result_t;

	localparam int RES_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== src/bhc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bhc_cfg_regs (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [bhc_pkg::CFG_W-1:0] cfg_wdata,
	output bhc_pkg::cfg_t                 cfg
);

	bhc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms       <= bhc_pkg::DEBOUNCE_RST;
			cfg_q.hold_ms           <= bhc_pkg::HOLD_RST;
			cfg_q.confirm_window_ms <= bhc_pkg::WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bhc_pkg::CFG_DEBOUNCE: cfg_q.debounce_ms       <= cfg_wdata;
				bhc_pkg::CFG_HOLD:     cfg_q.hold_ms           <= cfg_wdata;
				bhc_pkg::CFG_WINDOW:   cfg_q.confirm_window_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/bhc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bhc_core #(
	parameter int TIME_BITS = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step_en,
	input  wire bhc_pkg::item_t item,
	input  wire bhc_pkg::cfg_t  cfg,
	output bhc_pkg::result_t res
);

	localparam int CW = (TIME_BITS > bhc_pkg::CFG_W) ? TIME_BITS : bhc_pkg::CFG_W;

	bhc_pkg::phase_t        phase_q, n_phase;
	logic                   raw_q, n_raw;
	logic                   sl_q, n_sl;
	logic                   sv_q, n_sv;
	logic                   prompt_q, n_prompt;
	logic [TIME_BITS-1:0]   rct_q, n_rct;
	logic [TIME_BITS-1:0]   pst_q, n_pst;
	logic [TIME_BITS-1:0]   cst_q, n_cst;
	logic [TIME_BITS-1:0]   last_q, n_last;

	logic [CW-1:0] deb_w, hold_w, win_w;
	assign deb_w  = CW'(cfg.debounce_ms);
	assign hold_w = CW'(cfg.hold_ms);
	assign win_w  = CW'(cfg.confirm_window_ms);

	// elapsed time, wrapping at the timestamp width
	function automatic logic [CW-1:0] tdiff(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
		logic [TIME_BITS-1:0] d;
		d = a - b;
		return CW'(d);
	endfunction

	always_comb begin
		logic [TIME_BITS-1:0] now;
		logic                 lvl;
		logic                 was;
		logic                 fired;
		logic                 pending;
		logic [TIME_BITS-1:0] at;
		bhc_pkg::event_t      ev;
		bhc_pkg::event_t      ev_e;
		logic                 rearm;

		now      = TIME_BITS'(item.time_now);
		lvl      = item.button_level;
		was      = prompt_q;
		fired    = 1'b0;
		pending  = 1'b0;
		at       = '0;
		ev       = bhc_pkg::EV_NONE;
		ev_e     = bhc_pkg::EV_NONE;
		rearm    = 1'b0;
		n_phase  = phase_q;
		n_raw    = raw_q;
		n_sl     = sl_q;
		n_sv     = sv_q;
		n_prompt = prompt_q;
		n_rct    = rct_q;
		n_pst    = pst_q;
		n_cst    = cst_q;
		n_last   = last_q;

		case (item.kind)
			bhc_pkg::KIND_OBSERVE: begin
				if (phase_q == bhc_pkg::PH_COMMIT) begin
					ev = bhc_pkg::EV_NONE;
				end else if (now < last_q) begin
					n_phase  = bhc_pkg::PH_AWAIT;
					n_raw    = lvl;
					n_sl     = 1'b0;
					n_sv     = 1'b0;
					n_prompt = 1'b0;
					n_rct    = now;
					n_pst    = '0;
					n_cst    = '0;
					n_last   = now;
					ev       = was ? bhc_pkg::EV_CANCELLED : bhc_pkg::EV_NONE;
				end else begin
					n_last = now;
					if (lvl != raw_q) begin
						n_raw = lvl;
						n_rct = now;
					end
					// debounced edge, dated to the start of the raw change
					if ((!n_sv || n_sl != n_raw) && tdiff(now, n_rct) >= deb_w) begin
						n_sv = 1'b1;
						n_sl = n_raw;
						at   = n_rct;
						if (n_sl) begin
							if (n_phase == bhc_pkg::PH_IDLE) begin
								n_phase = bhc_pkg::PH_HOLD;
								n_pst   = at;
							end else if (n_phase == bhc_pkg::PH_CREADY) begin
								if (tdiff(at, n_cst) <= win_w) begin
									n_phase = bhc_pkg::PH_CPRESS;
								end else begin
									ev_e     = n_prompt ? bhc_pkg::EV_CANCELLED
									                    : bhc_pkg::EV_NONE;
									n_prompt = 1'b0;
									n_pst    = '0;
									n_cst    = '0;
									n_phase  = (n_raw || (n_sv && n_sl)) ? bhc_pkg::PH_AWAIT
									                                     : bhc_pkg::PH_IDLE;
								end
							end
						end else begin
							case (n_phase)
								bhc_pkg::PH_AWAIT: n_phase = bhc_pkg::PH_IDLE;
								bhc_pkg::PH_HOLD: begin
									if (tdiff(at, n_pst) < hold_w) begin
										n_phase = bhc_pkg::PH_IDLE;
									end else begin
										n_prompt = 1'b1;
										n_cst    = at;
										n_phase  = bhc_pkg::PH_CREADY;
										ev_e     = bhc_pkg::EV_PROMPT;
									end
									n_pst = '0;
								end
								bhc_pkg::PH_PHELD: begin
									n_cst   = at;
									n_phase = bhc_pkg::PH_CREADY;
								end
								bhc_pkg::PH_CPRESS: begin
									if (tdiff(at, n_cst) <= win_w) begin
										n_prompt = 1'b0;
										n_phase  = bhc_pkg::PH_COMMIT;
										ev_e     = bhc_pkg::EV_COMMIT;
									end else begin
										ev_e     = n_prompt ? bhc_pkg::EV_CANCELLED
										                    : bhc_pkg::EV_NONE;
										n_prompt = 1'b0;
										n_pst    = '0;
										n_cst    = '0;
										n_phase  = (n_raw || (n_sv && n_sl))
										           ? bhc_pkg::PH_AWAIT : bhc_pkg::PH_IDLE;
									end
								end
								default: ;
							endcase
						end
						if (ev_e != bhc_pkg::EV_NONE) begin
							ev    = ev_e;
							fired = 1'b1;
						end
					end
					if (!fired) begin
						if (n_phase == bhc_pkg::PH_HOLD && n_raw && n_sl &&
						    tdiff(now, n_pst) >= hold_w) begin
							n_prompt = 1'b1;
							n_phase  = bhc_pkg::PH_PHELD;
							ev       = bhc_pkg::EV_PROMPT;
						end else if ((n_phase == bhc_pkg::PH_CREADY ||
						              n_phase == bhc_pkg::PH_CPRESS) &&
						             tdiff(now, n_cst) > win_w) begin
							pending = (n_phase == bhc_pkg::PH_CPRESS) && n_sl && !n_raw &&
							          (tdiff(n_rct, n_cst) <= win_w);
							if (!pending) begin
								ev       = n_prompt ? bhc_pkg::EV_CANCELLED
								                    : bhc_pkg::EV_NONE;
								n_prompt = 1'b0;
								n_pst    = '0;
								n_cst    = '0;
								n_phase  = (n_raw || (n_sv && n_sl)) ? bhc_pkg::PH_AWAIT
								                                     : bhc_pkg::PH_IDLE;
							end
						end
					end
				end
			end
			bhc_pkg::KIND_CANCEL, bhc_pkg::KIND_REARM: begin
				if ((item.kind == bhc_pkg::KIND_CANCEL) != (phase_q == bhc_pkg::PH_COMMIT)) begin
					n_phase  = bhc_pkg::PH_AWAIT;
					n_raw    = lvl;
					n_sl     = 1'b0;
					n_sv     = 1'b0;
					n_prompt = 1'b0;
					n_rct    = now;
					n_pst    = '0;
					n_cst    = '0;
					n_last   = now;
					if (item.kind == bhc_pkg::KIND_CANCEL) begin
						ev = was ? bhc_pkg::EV_CANCELLED : bhc_pkg::EV_NONE;
					end else begin
						rearm = 1'b1;
					end
				end
			end
			default: ;
		endcase

		res.event_code     = ev;
		res.rearm_accepted = rearm;
		res.prompt_shown   = n_prompt;
		res.phase_now      = n_phase;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bhc_pkg::PH_AWAIT;
			raw_q    <= 1'b0;
			sl_q     <= 1'b0;
			sv_q     <= 1'b0;
			prompt_q <= 1'b0;
			rct_q    <= '0;
			pst_q    <= '0;
			cst_q    <= '0;
			last_q   <= '0;
		end else if (step_en) begin
			phase_q  <= n_phase;
			raw_q    <= n_raw;
			sl_q     <= n_sl;
			sv_q     <= n_sv;
			prompt_q <= n_prompt;
			rct_q    <= n_rct;
			pst_q    <= n_pst;
			cst_q    <= n_cst;
			last_q   <= n_last;
		end
	end

	a_rearm_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.rearm_accepted |-> phase_q == bhc_pkg::PH_COMMIT)
		else $error("rearm accepted outside commit phase");

	a_commit_enters_commit: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.event_code == bhc_pkg::EV_COMMIT |=> phase_q == bhc_pkg::PH_COMMIT)
		else $error("commit event without commit phase");

	a_prompt_phase: assert property (@(posedge clk) disable iff (!arst_n)
		prompt_q |-> (phase_q == bhc_pkg::PH_PHELD || phase_q == bhc_pkg::PH_CREADY ||
		              phase_q == bhc_pkg::PH_CPRESS))
		else $error("prompt shown in a phase without prompt");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(phase_q) && $stable(prompt_q) && $stable(last_q))
		else $error("state moved without a word");

endmodule

`default_nettype wire

// ===== src/bhc_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bhc_out_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire bhc_pkg::result_t push_data,
	output logic                  ready,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata
);

	bhc_pkg::result_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign ready    = cnt_q != 2'd2;
	assign m_tvalid = cnt_q != 2'd0;
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = {{(8 - bhc_pkg::RES_W){1'b0}}, mem_q[rd_ptr_q]};

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== src/button_hold_confirm_gesture_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Button hold-and-confirm gesture recognizer. Each slave word carries a raw
// button sample, an external cancel or a rearm, with a millisecond timestamp;
// each produces exactly one master word with the event code, the rearm flag,
// the prompt flag and the gesture phase. One word is taken per clock while the
// output buffer has room: the input register feeds the state update in the core,
// and its result lands in a two-word output buffer, so a result is offered on the
// master side once its word has passed the input register and the output buffer.
// Thresholds reset to 50 / 10000 / 5000 ms and are written through cfg_we / cfg_index
// (0 debounce, 1 hold, 2 confirm window) by the user while idle; the block does not check.
module button_hold_confirm_gesture_top #(
	parameter int TIME_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // button_level, time_now[31:0]
	input  wire logic [1:0]  s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // event_code, rearm_accepted, prompt_shown, phase_now
);

	bhc_pkg::cfg_t    cfg;
	bhc_pkg::item_t   item_s1;
	logic             valid_s1;
	logic             fifo_rdy;
	logic             advance;
	bhc_pkg::result_t res;

	assign advance  = valid_s1 && fifo_rdy;
	assign s_tready = !valid_s1 || fifo_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind         <= s_tuser;
			item_s1.button_level <= s_tdata[0];
			item_s1.time_now     <= s_tdata[32:1];
		end
	end

	bhc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bhc_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	bhc_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (res),
		.ready     (fifo_rdy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
